/* design/calendar_date_add_days_core_assert.svh */
// Assertion macros shared by the checker of the date adder.
`ifndef CALENDAR_DATE_ADD_DAYS_CORE_ASSERT_SVH
`define CALENDAR_DATE_ADD_DAYS_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CDAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/cdad_pkg.sv */
// Package with the microcode types, program counter codes and month table.
`default_nettype none

package cdad_pkg;

	typedef logic [2:0] pc_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_MOD,
		OP_CLAMPD,
		OP_BSTEP,
		OP_FSTEP,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_NSTART,
		COND_GE400,
		COND_POS,
		COND_NEG
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ucw_t;

	typedef struct packed {
		logic ge400;
		logic r_pos;
		logic r_neg;
	} dp_status_t;

	localparam pc_t PC_IDLE   = 3'd0;
	localparam pc_t PC_MOD    = 3'd1;
	localparam pc_t PC_CLAMP  = 3'd2;
	localparam pc_t PC_TEST   = 3'd3;
	localparam pc_t PC_BWD    = 3'd4;
	localparam pc_t PC_BEXIT  = 3'd5;
	localparam pc_t PC_FWD    = 3'd6;
	localparam pc_t PC_DONE   = 3'd7;

	localparam logic [3:0]  MONTH_JAN = 4'd1;
	localparam logic [3:0]  MONTH_FEB = 4'd2;
	localparam logic [3:0]  MONTH_DEC = 4'd12;
	localparam logic [4:0]  DAY_FIRST = 5'd1;
	localparam logic [4:0]  DAY_DEC31 = 5'd31;
	localparam logic [15:0] YEAR_MIN = 16'd0;
	localparam logic [15:0] YEAR_MAX = 16'hFFFF;
	localparam logic [15:0] LEAP_CYCLE = 16'd400;
	localparam logic [8:0]  CYCLE_LAST = 9'd399;

	function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

/* design/cdad_urom.sv */
// Microcode program store of the date adder.
`default_nettype none

module cdad_urom (
	input  cdad_pkg::pc_t  pc,
	output cdad_pkg::ucw_t cw
);
	import cdad_pkg::*;

	always_comb begin
		case (pc)
			PC_IDLE:  cw = '{op: OP_LOAD,   cond: COND_NSTART, target: PC_IDLE};
			PC_MOD:   cw = '{op: OP_MOD,    cond: COND_GE400,  target: PC_MOD};
			PC_CLAMP: cw = '{op: OP_CLAMPD, cond: COND_NEXT,   target: PC_TEST};
			PC_TEST:  cw = '{op: OP_NOP,    cond: COND_POS,    target: PC_FWD};
			PC_BWD:   cw = '{op: OP_BSTEP,  cond: COND_NEG,    target: PC_BWD};
			PC_BEXIT: cw = '{op: OP_NOP,    cond: COND_ALWAYS, target: PC_DONE};
			PC_FWD:   cw = '{op: OP_FSTEP,  cond: COND_POS,    target: PC_FWD};
			PC_DONE:  cw = '{op: OP_EMIT,   cond: COND_ALWAYS, target: PC_IDLE};
			default:  cw = '{op: OP_NOP,    cond: COND_ALWAYS, target: PC_IDLE};
		endcase
	end

endmodule

`default_nettype wire

/* design/cdad_seq.sv */
// Microcode sequencer: step counter, branch evaluation and operation issue.
`default_nettype none

module cdad_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  cdad_pkg::dp_status_t   status,
	output cdad_pkg::op_t          op,
	output logic                   busy
);
	import cdad_pkg::*;

	pc_t  pc_q;
	pc_t  pc_d;
	ucw_t cw;
	logic take;

	cdad_urom u_urom (
		.pc(pc_q),
		.cw(cw)
	);

	always_comb begin
		case (cw.cond)
			COND_NEXT:   take = 1'b0;
			COND_ALWAYS: take = 1'b1;
			COND_NSTART: take = !start;
			COND_GE400:  take = status.ge400;
			COND_POS:    take = status.r_pos;
			COND_NEG:    take = status.r_neg;
			default:     take = 1'b0;
		endcase
	end

	always_comb begin
		pc_d = take ? cw.target : pc_q + 3'd1;
		if (cw.cond == COND_NSTART && take) begin
			op = OP_NOP;
		end else begin
			op = cw.op;
		end
	end

	assign busy = (pc_q != PC_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

`default_nettype wire

/* design/cdad_dp.sv */
// Datapath of the date adder: date registers, remaining offset and result registers.
`default_nettype none

module cdad_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cdad_pkg::op_t        op,
	input  logic [3:0]           month_in,
	input  logic [4:0]           day_in,
	input  logic [15:0]          year_in,
	input  logic signed [20:0]   day_offset,
	output cdad_pkg::dp_status_t status,
	output logic                 done,
	output logic [3:0]           month_out,
	output logic [4:0]           day_out,
	output logic [15:0]          year_out,
	output logic                 input_corrected,
	output logic                 year_out_of_range
);
	import cdad_pkg::*;

	logic [3:0]         m_q;
	logic [4:0]         d_q;
	logic [15:0]        y_q;
	logic [15:0]        w_q;
	logic signed [21:0] r_q;
	logic               corr_q;
	logic               oor_q;
	logic               done_q;

	logic [8:0]  w9;
	logic        leap;
	logic [4:0]  len_cur;
	logic [4:0]  len_prev;
	logic [4:0]  rem;
	logic [21:0] neg_r;

	always_comb begin
		w9 = w_q[8:0];
		leap = (w9[1:0] == 2'd0) && (w9 != 9'd100) && (w9 != 9'd200) && (w9 != 9'd300);
		len_cur = days_in_month(m_q, leap);
		len_prev = days_in_month(m_q - 4'd1, leap);
		rem = len_cur - d_q;
		neg_r = 22'(-r_q);
		status.ge400 = (w_q >= LEAP_CYCLE);
		status.r_pos = !r_q[21] && (r_q != 22'sd0);
		status.r_neg = r_q[21];
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				if (month_in > MONTH_DEC) begin
					m_q <= MONTH_DEC;
					corr_q <= 1'b1;
				end else if (month_in == 4'd0) begin
					m_q <= MONTH_JAN;
					corr_q <= 1'b1;
				end else begin
					m_q <= month_in;
					corr_q <= 1'b0;
				end
				d_q <= day_in;
				y_q <= year_in;
				w_q <= year_in;
				r_q <= 22'(day_offset);
				oor_q <= 1'b0;
			end
			OP_MOD: begin
				if (status.ge400) begin
					w_q <= w_q - LEAP_CYCLE;
				end
			end
			OP_CLAMPD: begin
				if (d_q > len_cur) begin
					d_q <= len_cur;
					corr_q <= 1'b1;
				end else if (d_q == 5'd0) begin
					d_q <= DAY_FIRST;
					corr_q <= 1'b1;
				end
			end
			OP_FSTEP: begin
				if (status.r_pos) begin
					if ($unsigned(r_q) <= {17'd0, rem}) begin
						d_q <= d_q + r_q[4:0];
						r_q <= '0;
					end else if (m_q == MONTH_DEC && y_q == YEAR_MAX) begin
						m_q <= MONTH_DEC;
						d_q <= DAY_DEC31;
						r_q <= '0;
						oor_q <= 1'b1;
					end else begin
						r_q <= r_q - $signed({17'd0, rem}) - 22'sd1;
						d_q <= DAY_FIRST;
						if (m_q == MONTH_DEC) begin
							m_q <= MONTH_JAN;
							y_q <= y_q + 16'd1;
							w_q <= (w9 == CYCLE_LAST) ? 16'd0 : w_q + 16'd1;
						end else begin
							m_q <= m_q + 4'd1;
						end
					end
				end
			end
			OP_BSTEP: begin
				if (status.r_neg) begin
					if (neg_r < {17'd0, d_q}) begin
						d_q <= d_q - neg_r[4:0];
						r_q <= '0;
					end else if (m_q == MONTH_JAN && y_q == YEAR_MIN) begin
						d_q <= DAY_FIRST;
						r_q <= '0;
						oor_q <= 1'b1;
					end else begin
						r_q <= r_q + $signed({17'd0, d_q});
						if (m_q == MONTH_JAN) begin
							m_q <= MONTH_DEC;
							d_q <= DAY_DEC31;
							y_q <= y_q - 16'd1;
							w_q <= (w9 == 9'd0) ? {7'd0, CYCLE_LAST} : w_q - 16'd1;
						end else begin
							m_q <= m_q - 4'd1;
							d_q <= len_prev;
						end
					end
				end
			end
			OP_EMIT: begin
				month_out <= m_q;
				day_out <= d_q;
				year_out <= y_q;
				input_corrected <= corr_q;
				year_out_of_range <= oor_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (op == OP_EMIT);
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

/* design/calendar_date_add_days_core.sv */
// Top level of the Gregorian date adder: a date plus a signed day offset.
//
// A transaction is accepted at a rising edge with start high and busy low; the
// inputs month_in, day_in, year_in and day_offset are sampled at that edge.
// The start date is clamped to a valid date, then the offset is walked one
// month per cycle forward or backward. The result appears on month_out,
// day_out, year_out, input_corrected and year_out_of_range, marked by done,
// which is high for a single cycle; the receiver cannot stall it and must
// take it then. The time from accept to done grows with year_in, which is
// reduced modulo 400 by repeated subtraction, and with the number of month
// boundaries crossed in the month loop (up to about 34500 for big offsets).
// busy stays high for the whole transaction and one item is in flight at a
// time; a new transaction may be accepted in the cycle that done is shown.
// Reset clears the sequencer and the done strobe; the block comes out of
// reset idle and ready for a transaction.
`default_nettype none

module calendar_date_add_days_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         month_in,
	input  logic [4:0]         day_in,
	input  logic [15:0]        year_in,
	input  logic signed [20:0] day_offset,
	output logic               done,
	output logic [3:0]         month_out,
	output logic [4:0]         day_out,
	output logic [15:0]        year_out,
	output logic               input_corrected,
	output logic               year_out_of_range
);
	import cdad_pkg::*;

	op_t        op;
	dp_status_t status;

	cdad_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.status(status),
		.op(op),
		.busy(busy)
	);

	cdad_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.month_in(month_in),
		.day_in(day_in),
		.year_in(year_in),
		.day_offset(day_offset),
		.status(status),
		.done(done),
		.month_out(month_out),
		.day_out(day_out),
		.year_out(year_out),
		.input_corrected(input_corrected),
		.year_out_of_range(year_out_of_range)
	);

endmodule

`default_nettype wire

/* design/cdad_checker.sv */
// Port-level checker of the date adder and its bind to the top level.
`default_nettype none

`include "calendar_date_add_days_core_assert.svh"

module cdad_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [3:0]  month_out,
	input logic [4:0]  day_out,
	input logic [15:0] year_out,
	input logic        year_out_of_range
);

	`CDAD_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted transaction did not raise busy")

	`CDAD_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done, "done held for more than one cycle")

	`CDAD_ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy), "done without a transaction in flight")

	`CDAD_ASSERT_IMP(a_date_valid, clk, arst_n, done, month_out >= 4'd1 && month_out <= 4'd12 && day_out >= 5'd1, "result date out of range")

	`CDAD_ASSERT_IMP(a_saturate, clk, arst_n, done && year_out_of_range, (month_out == 4'd1 && day_out == 5'd1 && year_out == 16'd0) || (month_out == 4'd12 && day_out == 5'd31 && year_out == 16'hFFFF), "saturated result is not a limit date")

endmodule

bind calendar_date_add_days_core cdad_checker u_cdad_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.month_out(month_out),
	.day_out(day_out),
	.year_out(year_out),
	.year_out_of_range(year_out_of_range)
);

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench of the Gregorian date adder with its own date arithmetic.
`timescale 1ns / 1ps

module testbench;
	import cdad_pkg::*;

	localparam int CYCLE_LIMIT = 20_000_000;
	localparam int DRAIN_CYCLES = 200;
	localparam int MAX_PRINTED = 200;
	localparam int RANDOM_ITEMS = 100;
	localparam longint DAYS_PER_ERA = 146097;
	localparam longint YEAR_SHIFT = 400;

	typedef struct {
		logic [3:0]  month;
		logic [4:0]  day;
		logic [15:0] year;
		logic        corrected;
		logic        out_of_range;
	} date_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [3:0] month_in;
	logic [4:0] day_in;
	logic [15:0] year_in;
	logic signed [20:0] day_offset;
	logic done;
	logic [3:0] month_out;
	logic [4:0] day_out;
	logic [15:0] year_out;
	logic input_corrected;
	logic year_out_of_range;

	date_result_t expected_dates[$];
	int error_count = 0;
	int cycle_count = 0;
	bit gaps_enabled = 1'b1;

	calendar_date_add_days_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.month_in(month_in),
		.day_in(day_in),
		.year_in(year_in),
		.day_offset(day_offset),
		.done(done),
		.month_out(month_out),
		.day_out(day_out),
		.year_out(year_out),
		.input_corrected(input_corrected),
		.year_out_of_range(year_out_of_range)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic bit is_leap(input longint y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic longint month_length(input longint m, input longint y);
		if (m == MONTH_FEB)
			return is_leap(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	// Serial day count starting at March 1 of the year one era before year 0.
	function automatic longint date_serial(input longint m, input longint d, input longint y);
		longint yy, era, yoe, mp, doy;
		yy = y + YEAR_SHIFT - ((m <= MONTH_FEB) ? 1 : 0);
		era = yy / 400;
		yoe = yy - era * 400;
		mp = (m > MONTH_FEB) ? m - 3 : m + 9;
		doy = (153 * mp + 2) / 5 + d - 1;
		return era * DAYS_PER_ERA + yoe * 365 + yoe / 4 - yoe / 100 + doy;
	endfunction

	function automatic date_result_t predict_date_sum(input logic [3:0] m_raw,
			input logic [4:0] d_raw, input logic [15:0] y_raw, input logic signed [20:0] off);
		date_result_t r;
		longint m, d, y, len, z, era, doe, yoe, doy, mp, dd, mm;
		m = m_raw;
		d = d_raw;
		y = y_raw;
		r.corrected = 1'b0;
		r.out_of_range = 1'b0;
		if (m > MONTH_DEC) begin
			m = MONTH_DEC;
			r.corrected = 1'b1;
		end else if (m < MONTH_JAN) begin
			m = MONTH_JAN;
			r.corrected = 1'b1;
		end
		len = month_length(m, y);
		if (d > len) begin
			d = len;
			r.corrected = 1'b1;
		end else if (d < 1) begin
			d = 1;
			r.corrected = 1'b1;
		end
		z = date_serial(m, d, y) + longint'(off);
		if (z < date_serial(MONTH_JAN, DAY_FIRST, YEAR_MIN)) begin
			r.month = MONTH_JAN;
			r.day = DAY_FIRST;
			r.year = YEAR_MIN;
			r.out_of_range = 1'b1;
		end else if (z > date_serial(MONTH_DEC, DAY_DEC31, YEAR_MAX)) begin
			r.month = MONTH_DEC;
			r.day = DAY_DEC31;
			r.year = YEAR_MAX;
			r.out_of_range = 1'b1;
		end else begin
			era = z / DAYS_PER_ERA;
			doe = z - era * DAYS_PER_ERA;
			yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
			doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
			mp = (5 * doy + 2) / 153;
			dd = doy - (153 * mp + 2) / 5 + 1;
			mm = (mp < 10) ? mp + 3 : mp - 9;
			r.month = mm[3:0];
			r.day = dd[4:0];
			r.year = 16'(yoe + era * 400 + ((mm <= MONTH_FEB) ? 1 : 0) - YEAR_SHIFT);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		if (error_count < MAX_PRINTED)
			$display("ERROR at %0t ns: %s", $time, what);
		error_count++;
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	always @(posedge clk) begin
		date_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_dates.size() == 0) begin
				report_mismatch("result with no transaction outstanding");
			end else begin
				want = expected_dates.pop_front();
				compare_field("month_out", month_out, want.month);
				compare_field("day_out", day_out, want.day);
				compare_field("year_out", year_out, want.year);
				compare_field("input_corrected", input_corrected, want.corrected);
				compare_field("year_out_of_range", year_out_of_range, want.out_of_range);
			end
		end
	end

	function automatic int gap_cycles();
		int sel;
		sel = $urandom_range(0, 99);
		if (!gaps_enabled || sel < 50)
			return 0;
		if (sel < 85)
			return $urandom_range(1, 3);
		if (sel < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic send_date(input logic [3:0] m, input logic [4:0] d, input logic [15:0] y,
			input logic signed [20:0] off);
		int gap;
		gap = gap_cycles();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		month_in <= m;
		day_in <= d;
		year_in <= y;
		day_offset <= off;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		expected_dates.push_back(predict_date_sum(m, d, y, off));
	endtask

	task automatic test_month_clamp();
		send_date(4'd0, 5'd15, 16'd2023, 21'sd10);
		send_date(4'd13, 5'd5, 16'd2023, 21'sd0);
		send_date(4'd15, 5'd31, 16'd2024, -21'sd1);
		send_date(4'd8, 5'd31, 16'd2023, 21'sd1);
	endtask

	task automatic test_day_clamp();
		send_date(4'd4, 5'd31, 16'd2023, 21'sd0);
		send_date(MONTH_FEB, 5'd30, 16'd2024, 21'sd0);
		send_date(MONTH_FEB, 5'd29, 16'd2023, 21'sd0);
		send_date(4'd6, 5'd0, 16'd2023, 21'sd0);
		send_date(MONTH_FEB, 5'd31, 16'd1900, 21'sd1);
	endtask

	task automatic test_leap_rules();
		send_date(MONTH_FEB, 5'd28, 16'd2000, 21'sd1);
		send_date(MONTH_FEB, 5'd28, 16'd1900, 21'sd1);
		send_date(MONTH_FEB, 5'd28, 16'd2024, 21'sd1);
		send_date(4'd3, DAY_FIRST, 16'd2100, -21'sd1);
		send_date(MONTH_FEB, 5'd28, YEAR_MIN, 21'sd1);
		send_date(MONTH_DEC, DAY_DEC31, 16'd1999, 21'sd366);
	endtask

	task automatic test_year_limits();
		send_date(MONTH_JAN, DAY_FIRST, YEAR_MIN, -21'sd1);
		send_date(MONTH_DEC, DAY_DEC31, YEAR_MAX, 21'sd1);
		send_date(MONTH_DEC, DAY_DEC31, YEAR_MAX, 21'sd0);
		send_date(MONTH_JAN, DAY_FIRST, YEAR_MIN, 21'sd0);
		send_date(MONTH_DEC, DAY_DEC31, YEAR_MAX, 21'sd1048575);
		send_date(MONTH_JAN, DAY_FIRST, YEAR_MIN, 21'h100000);
		send_date(MONTH_JAN, DAY_FIRST, YEAR_MIN, 21'sd1048575);
		send_date(MONTH_DEC, DAY_DEC31, YEAR_MAX, -21'sd1048575);
		send_date(4'd15, 5'd31, YEAR_MAX, 21'h100000);
	endtask

	// Most offsets are short so the month walk stays brief; a few span the full field.
	task automatic test_random_dates();
		logic [3:0] m;
		logic [4:0] d;
		logic [15:0] y;
		logic signed [20:0] off;
		logic [31:0] raw;
		int sel;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 16 == 0)
				gaps_enabled = ($urandom_range(0, 3) != 0);
			m = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
				4'($urandom_range(1, 12));
			d = ($urandom_range(0, 19) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
			sel = $urandom_range(0, 99);
			if (sel < 35)
				y = 16'($urandom_range(1900, 2100));
			else if (sel < 70)
				y = 16'($urandom_range(0, 65535));
			else if (sel < 85)
				y = 16'($urandom_range(0, 800));
			else
				y = 16'($urandom_range(65000, 65535));
			sel = $urandom_range(0, 99);
			raw = $urandom();
			if (sel < 80)
				off = 21'(int'($urandom_range(0, 8000)) - 4000);
			else if (sel < 95)
				off = 21'(int'($urandom_range(0, 120000)) - 60000);
			else
				off = raw[20:0];
			send_date(m, d, y, off);
		end
		gaps_enabled = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		month_in = '0;
		day_in = '0;
		year_in = '0;
		day_offset = '0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);
		test_month_clamp();
		test_day_clamp();
		test_leap_rules();
		test_year_limits();
		test_random_dates();
		start <= 1'b0;
		while (expected_dates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
